// ----- hw/rtl/esdf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esdf_pkg
// Shared types and constants for the epoch seconds to date fields converter.
// ----------------------------------------------------------------------------
package esdf_pkg;

   localparam logic [16:0] DAY_SECONDS    = 17'd86400;
   localparam logic [25:0] DAY_RECIP      = 26'd50903317;   // ceil(2^35 / 675)
   localparam int unsigned DAY_SHIFT      = 35;
   localparam logic [15:0] DAYS_1968_1970 = 16'd731;
   localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
   localparam logic [16:0] CYCLE_RECIP    = 17'd91868;      // ceil(2^27 / 1461)
   localparam int unsigned CYCLE_SHIFT    = 27;
   localparam logic [15:0] MIN_RECIP      = 16'd34953;      // ceil(2^19 / 15)
   localparam int unsigned MIN_SHIFT      = 19;
   localparam logic [9:0]  HOUR_RECIP     = 10'd547;        // ceil(2^13 / 15)
   localparam int unsigned HOUR_SHIFT     = 13;
   localparam logic [10:0] DAYS_LEAP_YEAR = 11'd366;
   localparam logic [10:0] DAYS_YEAR      = 11'd365;
   localparam logic [7:0]  BASE_YEAR      = 8'd68;
   localparam logic [8:0]  LEAP_DAY_DOY   = 9'd59;

   localparam logic [2:0]  ORDER_DMY      = 3'd1;
   localparam logic [2:0]  ORDER_YMD      = 3'd2;

   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   typedef struct packed {
      logic [3:0] month;
      logic [4:0] mday;
   } esdf_date_type;

endpackage
`default_nettype wire

// ----- hw/rtl/esdf_month_lookup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esdf_month_lookup
// Splits a day of year into month and day of month, leap day included.
// ----------------------------------------------------------------------------
module esdf_month_lookup (
   input  wire logic [8:0]             doy,
   input  wire logic                   leap,
   output esdf_pkg::esdf_date_type     date
);
   import esdf_pkg::*;

   logic [8:0] doy_adj;
   logic [3:0] month_idx;

   always_comb begin
      doy_adj = doy;
      if (leap && (doy > LEAP_DAY_DOY)) begin
         doy_adj = doy - 9'd1;
      end
      month_idx = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy_adj >= MONTH_START[m]) begin
            month_idx = 4'(m);
         end
      end
      if (leap && (doy == LEAP_DAY_DOY)) begin
         date.month = 4'd2;
         date.mday  = 5'd29;
      end else begin
         date.month = month_idx + 4'd1;
         date.mday  = 5'(doy_adj - MONTH_START[month_idx] + 9'd1);
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/epoch_seconds_to_date_fields_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_date_fields_top
// Converts seconds since 1970-01-01 into time of day and an ordered date.
// Pipeline: input register, four arithmetic stages, result register.
// Throughput: one request per cycle while the result side does not stall; the
// reciprocal multipliers are pipelined.
// Reset clears all valid flags and sets the date order to month-day-year.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_fields_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [31:0] req_seconds_since_epoch,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [6:0]  rsp_first_date_field,
   output      logic [6:0]  rsp_second_date_field,
   output      logic [6:0]  rsp_third_date_field,
   output      logic [4:0]  rsp_hour_of_day,
   output      logic [5:0]  rsp_minute_of_hour,
   output      logic [5:0]  rsp_second_of_minute,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_wr_data
);
   import esdf_pkg::*;

   logic [2:0]  date_order_ff;

   logic        v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic        en0, en1, en2, en3, en4, en5;

   // stage 0
   logic [31:0] t0_ff;
   // stage 1
   logic [50:0] day_prod;
   logic [15:0] days1_in, days1_ff;
   logic [16:0] tlo1_ff;
   // stage 2
   logic [32:0] day_secs, cyc_prod;
   logic [16:0] rem2_in, rem2_ff;
   logic [15:0] d2_in, d2_ff;
   logic [5:0]  cyc2_in, cyc2_ff;
   // stage 3
   logic [33:0] min_prod;
   logic [16:0] cyc_days;
   logic [10:0] totmin3_in, totmin3_ff;
   logic [10:0] r3_in, r3_ff;
   logic [16:0] rem3_ff;
   logic [5:0]  cyc3_ff;
   // stage 4
   logic [16:0] totmin_x60;
   logic [19:0] hour_prod;
   logic [5:0]  sec4_in, sec4_ff;
   logic [4:0]  hour4_in, hour4_ff;
   logic [10:0] totmin4_ff;
   logic [10:0] r_rest;
   logic [8:0]  doy4_in, doy4_ff;
   logic        leap4_in, leap4_ff;
   logic [1:0]  yoff;
   logic [7:0]  year_raw;
   logic [6:0]  year4_in, year4_ff;
   // stage 5
   esdf_date_type date5;
   logic [10:0] hour_x60;
   logic [5:0]  min5_in;
   logic [6:0]  f1_in, f2_in, f3_in;
   logic [6:0]  f1_ff, f2_ff, f3_ff;
   logic [4:0]  hour5_ff;
   logic [5:0]  min5_ff, sec5_ff;

   // stall handling: a stage moves when empty or when the next one moves
   assign en5 = !v5_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;
   assign req_stall = !en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         date_order_ff <= 3'd0;
      end else if (csr_wr_en) begin
         date_order_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en0) v0_ff <= req_valid;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // days = t / 86400, taken as (t >> 7) / 675
   always_comb begin
      day_prod = 51'(t0_ff[31:7]) * 51'(DAY_RECIP);
      days1_in = day_prod[DAY_SHIFT +: 16];
   end

   // seconds into the day and four-year cycle from 1968
   always_comb begin
      day_secs = 33'(days1_ff) * 33'(DAY_SECONDS);
      rem2_in  = tlo1_ff - day_secs[16:0];
      d2_in    = days1_ff + DAYS_1968_1970;
      cyc_prod = 33'(d2_in) * 33'(CYCLE_RECIP);
      cyc2_in  = cyc_prod[CYCLE_SHIFT +: 6];
   end

   always_comb begin
      min_prod   = 34'(rem2_ff[16:2]) * 34'(MIN_RECIP);
      totmin3_in = min_prod[MIN_SHIFT +: 11];
      cyc_days   = 17'(cyc2_ff) * 17'(DAYS_PER_CYCLE);
      r3_in      = d2_ff[10:0] - cyc_days[10:0];
   end

   always_comb begin
      totmin_x60 = 17'(totmin3_ff) * 17'd60;
      sec4_in    = rem3_ff[5:0] - totmin_x60[5:0];
      hour_prod  = 20'(totmin3_ff[10:2]) * 20'(HOUR_RECIP);
      hour4_in   = hour_prod[HOUR_SHIFT +: 5];

      r_rest = r3_ff - DAYS_LEAP_YEAR;
      if (r3_ff < DAYS_LEAP_YEAR) begin
         yoff     = 2'd0;
         doy4_in  = r3_ff[8:0];
         leap4_in = 1'b1;
      end else if (r_rest >= (DAYS_YEAR << 1)) begin
         yoff     = 2'd3;
         doy4_in  = 9'(r_rest - (DAYS_YEAR << 1));
         leap4_in = 1'b0;
      end else if (r_rest >= DAYS_YEAR) begin
         yoff     = 2'd2;
         doy4_in  = 9'(r_rest - DAYS_YEAR);
         leap4_in = 1'b0;
      end else begin
         yoff     = 2'd1;
         doy4_in  = r_rest[8:0];
         leap4_in = 1'b0;
      end

      year_raw = BASE_YEAR + {cyc3_ff, 2'b00} + 8'(yoff);
      if (year_raw >= 8'd200) begin
         year4_in = 7'(year_raw - 8'd200);
      end else if (year_raw >= 8'd100) begin
         year4_in = 7'(year_raw - 8'd100);
      end else begin
         year4_in = year_raw[6:0];
      end
   end

   esdf_month_lookup u_month_lookup (
      .doy  (doy4_ff),
      .leap (leap4_ff),
      .date (date5)
   );

   always_comb begin
      hour_x60 = 11'(hour4_ff) * 11'd60;
      min5_in  = totmin4_ff[5:0] - hour_x60[5:0];
      case (date_order_ff)
         ORDER_DMY: begin
            f1_in = 7'(date5.mday);
            f2_in = 7'(date5.month);
            f3_in = year4_ff;
         end
         ORDER_YMD: begin
            f1_in = year4_ff;
            f2_in = 7'(date5.month);
            f3_in = 7'(date5.mday);
         end
         default: begin
            f1_in = 7'(date5.month);
            f2_in = 7'(date5.mday);
            f3_in = year4_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         t0_ff <= req_seconds_since_epoch;
      end
      if (en1) begin
         days1_ff <= days1_in;
         tlo1_ff  <= t0_ff[16:0];
      end
      if (en2) begin
         rem2_ff <= rem2_in;
         d2_ff   <= d2_in;
         cyc2_ff <= cyc2_in;
      end
      if (en3) begin
         totmin3_ff <= totmin3_in;
         r3_ff      <= r3_in;
         rem3_ff    <= rem2_ff;
         cyc3_ff    <= cyc2_ff;
      end
      if (en4) begin
         sec4_ff    <= sec4_in;
         hour4_ff   <= hour4_in;
         totmin4_ff <= totmin3_ff;
         doy4_ff    <= doy4_in;
         leap4_ff   <= leap4_in;
         year4_ff   <= year4_in;
      end
      if (en5) begin
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         f3_ff    <= f3_in;
         hour5_ff <= hour4_ff;
         min5_ff  <= min5_in;
         sec5_ff  <= sec4_ff;
      end
   end

   assign rsp_valid             = v5_ff;
   assign rsp_first_date_field  = f1_ff;
   assign rsp_second_date_field = f2_ff;
   assign rsp_third_date_field  = f3_ff;
   assign rsp_hour_of_day       = hour5_ff;
   assign rsp_minute_of_hour    = min5_ff;
   assign rsp_second_of_minute  = sec5_ff;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v0_ff)
      else $error("accepted request not held in input stage");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (rem2_ff < DAY_SECONDS))
      else $error("seconds of day out of range");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (date5.month >= 4'd1 && date5.month <= 4'd12))
      else $error("month out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour_of_day < 5'd24 && rsp_minute_of_hour < 6'd60
                     && rsp_second_of_minute < 6'd60))
      else $error("time of day out of range");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && v4_ff && v3_ff && v2_ff && v1_ff && v0_ff)
         |-> req_stall)
      else $error("request taken with full pipeline stalled");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the epoch seconds to calendar fields converter.
// A queue of timestamps feeds a bursty request driver while the result side
// stalls in changing patterns. Every accepted request is converted to its
// expected time-of-day and ordered date fields by a local calendar model, and
// results are matched in order. Each date-order register value gets a phase.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DAY_SECONDS    = 86400;
   localparam int unsigned DAYS_TO_EPOCH  = 731;
   localparam int unsigned DAYS_PER_QUAD  = 1461;
   localparam int          PHASE_REQUESTS = 241;
   localparam int          SETTLE_CYCLES  = 12;
   localparam int          WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [6:0] first_date;
      logic [6:0] second_date;
      logic [6:0] third_date;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] sec;
   } date_fields_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_seconds_since_epoch = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_first_date_field;
   logic [6:0]  rsp_second_date_field;
   logic [6:0]  rsp_third_date_field;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_second_of_minute;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_wr_data = '0;

   logic [31:0]     pending_timestamps [$];
   date_fields_type expected_dates [$];
   date_fields_type oldest_date;
   logic [2:0]      order_shadow = '0;

   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_hold = 0;
   int cycle_count = 0;
   int idle_cycles = 0;
   int requests_sent = 0;
   int requests_queued = 0;
   int results_seen = 0;
   int fault_count = 0;
   int directed_count = 0;

   epoch_seconds_to_date_fields_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_seconds_since_epoch (req_seconds_since_epoch),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_first_date_field    (rsp_first_date_field),
      .rsp_second_date_field   (rsp_second_date_field),
      .rsp_third_date_field    (rsp_third_date_field),
      .rsp_hour_of_day         (rsp_hour_of_day),
      .rsp_minute_of_hour      (rsp_minute_of_hour),
      .rsp_second_of_minute    (rsp_second_of_minute),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic date_fields_type calendar_of(input logic [31:0] secs,
                                                   input logic [2:0] order);
      int unsigned day_count, sod, span, quad, quad_day, year_ofs, yday, yy, mon, mlen;
      bit leap;
      date_fields_type f;
      day_count = secs / DAY_SECONDS;
      sod = secs % DAY_SECONDS;
      // years counted from 1968 so every quad starts on a leap year
      span = day_count + DAYS_TO_EPOCH;
      quad = span / DAYS_PER_QUAD;
      quad_day = span % DAYS_PER_QUAD;
      if (quad_day < 366) begin
         leap = 1'b1;
         year_ofs = 0;
         yday = quad_day;
      end else begin
         leap = 1'b0;
         quad_day = quad_day - 366;
         year_ofs = 1 + quad_day / 365;
         yday = quad_day % 365;
      end
      yy = (68 + 4 * quad + year_ofs) % 100;
      mon = 1;
      mlen = 31;
      while (yday >= mlen) begin
         yday = yday - mlen;
         mon = mon + 1;
         case (mon)
            2: begin
               mlen = leap ? 29 : 28;
            end
            4, 6, 9, 11: begin
               mlen = 30;
            end
            default: begin
               mlen = 31;
            end
         endcase
      end
      case (order)
         esdf_pkg::ORDER_DMY: begin
            f.first_date = 7'(yday + 1);
            f.second_date = 7'(mon);
            f.third_date = 7'(yy);
         end
         esdf_pkg::ORDER_YMD: begin
            f.first_date = 7'(yy);
            f.second_date = 7'(mon);
            f.third_date = 7'(yday + 1);
         end
         default: begin
            f.first_date = 7'(mon);
            f.second_date = 7'(yday + 1);
            f.third_date = 7'(yy);
         end
      endcase
      f.hour = 5'(sod / 3600);
      f.minute = 6'((sod / 60) % 60);
      f.sec = 6'(sod % 60);
      return f;
   endfunction

   function automatic logic [31:0] pick_timestamp();
      longint unsigned days, offset, anchor;
      case ($urandom_range(0, 3))
         0: begin
            offset = 0;
         end
         1: begin
            offset = DAY_SECONDS - 1;
         end
         2: begin
            offset = 3600 * $urandom_range(0, 23) + 59 * 60 + 59;
         end
         default: begin
            offset = $urandom_range(0, DAY_SECONDS - 1);
         end
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            return $urandom;
         end
         4, 5, 6: begin
            days = $urandom_range(0, 49709);
         end
         default: begin
            // land near leap days and year ends
            case ($urandom_range(0, 10))
               0: anchor = 0;
               1: anchor = 1;
               2: anchor = 58;
               3: anchor = 59;
               4: anchor = 60;
               5: anchor = 365;
               6: anchor = 366;
               7: anchor = 424;
               8: anchor = 730;
               9: anchor = 1095;
               default: anchor = 1460;
            endcase
            days = DAYS_PER_QUAD * $urandom_range(0, 34) + anchor;
            if (days < DAYS_TO_EPOCH)
               days = days + DAYS_PER_QUAD;
            days = days - DAYS_TO_EPOCH;
            if (days > 49709)
               days = days - DAYS_PER_QUAD;
         end
      endcase
      return 32'(days * DAY_SECONDS + offset);
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fault_count++;
      end
   endtask

   task automatic wait_quiet();
      while (pending_timestamps.size() != 0 || expected_dates.size() != 0
             || results_seen < requests_queued)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_date_order(input logic [2:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      order_shadow = value;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_dates.push_back(calendar_of(req_seconds_since_epoch, order_shadow));
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_timestamps.size() != 0) begin
               req_valid <= 1'b1;
               req_seconds_since_epoch <= pending_timestamps.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor, stall pattern and watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         idle_cycles = 0;
      end else begin
         cycle_count++;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_dates.size() == 0) begin
               $error("result arrived with no request outstanding");
               fault_count++;
            end else begin
               oldest_date = expected_dates.pop_front();
               compare_field("first_date_field", oldest_date.first_date,
                             rsp_first_date_field);
               compare_field("second_date_field", oldest_date.second_date,
                             rsp_second_date_field);
               compare_field("third_date_field", oldest_date.third_date,
                             rsp_third_date_field);
               compare_field("hour_of_day", oldest_date.hour, rsp_hour_of_day);
               compare_field("minute_of_hour", oldest_date.minute, rsp_minute_of_hour);
               compare_field("second_of_minute", oldest_date.sec, rsp_second_of_minute);
            end
         end
         if (stall_hold == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_hold = $urandom_range(50, 300);
         end else begin
            stall_hold = stall_hold - 1;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ((cycle_count % 7) < 3);
            end
         endcase
         if ((pending_timestamps.size() == 0 && expected_dates.size() == 0)
             || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // epoch edges, leap days, century turns, sign boundary, all-ones
      pending_timestamps.push_back(32'd0);
      pending_timestamps.push_back(32'd86399);
      pending_timestamps.push_back(32'd86400);
      pending_timestamps.push_back(32'd68169599);
      pending_timestamps.push_back(32'd68169600);
      pending_timestamps.push_back(32'd68255999);
      pending_timestamps.push_back(32'd946684799);
      pending_timestamps.push_back(32'd946684800);
      pending_timestamps.push_back(32'd951782399);
      pending_timestamps.push_back(32'd951782400);
      pending_timestamps.push_back(32'd951868800);
      pending_timestamps.push_back(32'd1230767999);
      pending_timestamps.push_back(32'd2147483647);
      pending_timestamps.push_back(32'd2147483648);
      pending_timestamps.push_back(32'd4102444799);
      pending_timestamps.push_back(32'd4102444800);
      pending_timestamps.push_back(32'd4107542400);
      pending_timestamps.push_back(32'd4107628800);
      pending_timestamps.push_back(32'h5555_5555);
      pending_timestamps.push_back(32'hAAAA_AAAA);
      pending_timestamps.push_back(32'hFFFF_FFFF);
      directed_count = pending_timestamps.size();
      requests_queued = directed_count;
      wait_quiet();

      // visit every register value, extremes included
      for (int phase = 0; phase < 8; phase++) begin
         write_date_order(3'((phase * 5 + 1) % 8));
         for (int n = 0; n < PHASE_REQUESTS; n++)
            pending_timestamps.push_back(pick_timestamp());
         requests_queued += PHASE_REQUESTS;
         wait_quiet();
      end

      $display("%0d requests sent, %0d results checked (%0d directed timestamps)",
               requests_sent, results_seen, directed_count);
      $display("all eight date-order settings exercised under bursty requests and stalls");
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
